// ===== rtl/mnfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mnfc_pkg
// Shared constants, types and signature ROM for the magic-number classifier.
// ----------------------------------------------------------------------------
package mnfc_pkg;

  localparam int SIG_COUNT     = 29;
  localparam int MAX_SIG_BYTES = 28;

  localparam int POS_W   = 6;
  localparam int WIN_W   = 6;
  localparam int CODE_W  = 5;
  localparam int SLEN_W  = 5;

  localparam logic [POS_W-1:0]  POS_MAX       = 6'd63;
  localparam logic [CODE_W-1:0] CODE_HTML     = 5'd29;
  localparam logic [CODE_W-1:0] CODE_OTHER    = 5'd30;
  localparam logic [WIN_W-1:0]  HTML_WIN_RST  = 6'd20;

  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_HTML_WINDOW = 1'b0;

  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_M = 8'h6D;
  localparam logic [7:0] CH_L = 8'h6C;

  typedef logic [0:MAX_SIG_BYTES-1][7:0] sig_row_t;

  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_H;
      2'd1:    c = CH_T;
      2'd2:    c = CH_M;
      default: c = CH_L;
    endcase
    return c;
  endfunction

  function automatic logic [SLEN_W-1:0] sig_len(input logic [4:0] idx);
    logic [SLEN_W-1:0] l;
    case (idx)
      5'd0:  l = 5'd3;
      5'd1:  l = 5'd3;
      5'd2:  l = 5'd4;
      5'd3:  l = 5'd4;
      5'd4:  l = 5'd4;
      5'd5:  l = 5'd6;
      5'd6:  l = 5'd6;
      5'd7:  l = 5'd4;
      5'd8:  l = 5'd3;
      5'd9:  l = 5'd16;
      5'd10: l = 5'd3;
      5'd11: l = 5'd4;
      5'd12: l = 5'd2;
      5'd13: l = 5'd9;
      5'd14: l = 5'd7;
      5'd15: l = 5'd3;
      5'd16: l = 5'd9;
      5'd17: l = 5'd12;
      5'd18: l = 5'd8;
      5'd19: l = 5'd3;
      5'd20: l = 5'd4;
      5'd21: l = 5'd28;
      5'd22: l = 5'd4;
      5'd23: l = 5'd14;
      5'd24: l = 5'd4;
      5'd25: l = 5'd1;
      5'd26: l = 5'd16;
      5'd27: l = 5'd9;
      5'd28: l = 5'd4;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

  function automatic sig_row_t sig_row(input logic [4:0] idx);
    sig_row_t r;
    case (idx)
      5'd0:  r = {8'h43, 8'h57, 8'h53, {25{8'h00}}};
      5'd1:  r = {8'h46, 8'h57, 8'h53, {25{8'h00}}};
      5'd2:  r = {8'h7F, 8'h45, 8'h4C, 8'h46, {24{8'h00}}};
      5'd3:  r = {8'hCA, 8'hFE, 8'hBA, 8'hBE, {24{8'h00}}};
      5'd4:  r = {8'h50, 8'h4B, 8'h03, 8'h04, {24{8'h00}}};
      5'd5:  r = {8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, {22{8'h00}}};
      5'd6:  r = {8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, {22{8'h00}}};
      5'd7:  r = {8'h4D, 8'h53, 8'h43, 8'h46, {24{8'h00}}};
      5'd8:  r = {8'hFF, 8'hD8, 8'hFF, {25{8'h00}}};
      5'd9:  r = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
                  8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52,
                  {12{8'h00}}};
      5'd10: r = {8'h00, 8'h00, 8'h01, {25{8'h00}}};
      5'd11: r = {8'h47, 8'h49, 8'h46, 8'h38, {24{8'h00}}};
      5'd12: r = {8'h42, 8'h4D, {26{8'h00}}};
      5'd13: r = {8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A, 8'hE1,
                  8'h00, {19{8'h00}}};
      5'd14: r = {8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h31, 8'h2E, {21{8'h00}}};
      5'd15: r = {8'h49, 8'h44, 8'h33, {25{8'h00}}};
      5'd16: r = {8'h23, 8'h45, 8'h58, 8'h54, 8'h4D, 8'h33, 8'h55, 8'h0D,
                  8'h0A, {19{8'h00}}};
      5'd17: r = {8'hEF, 8'hBB, 8'hBF, 8'h23, 8'h45, 8'h58, 8'h54, 8'h4D,
                  8'h33, 8'h55, 8'h0D, 8'h0A, {16{8'h00}}};
      5'd18: r = {8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h22,
                  {20{8'h00}}};
      5'd19: r = {8'h00, 8'h00, 8'h00, {25{8'h00}}};
      5'd20: r = {8'h46, 8'h4C, 8'h56, 8'h01, {24{8'h00}}};
      5'd21: r = {8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h93, 8'h42, 8'h82, 8'h88,
                  8'h6D, 8'h61, 8'h74, 8'h72, 8'h6F, 8'h73, 8'h6B, 8'h61,
                  8'h42, 8'h87, 8'h81, 8'h01, 8'h42, 8'h85, 8'h81, 8'h01,
                  8'h18, 8'h53, 8'h80, 8'h67};
      5'd22: r = {8'h00, 8'h00, 8'h01, 8'hBA, {24{8'h00}}};
      5'd23: r = {8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h02, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, {14{8'h00}}};
      5'd24: r = {8'h52, 8'h49, 8'h46, 8'h46, {24{8'h00}}};
      5'd25: r = {8'h6D, {27{8'h00}}};
      5'd26: r = {8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
                  8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C,
                  {12{8'h00}}};
      5'd27: r = {8'h2E, 8'h52, 8'h4D, 8'h46, 8'h00, 8'h00, 8'h00, 8'h12,
                  8'h00, {19{8'h00}}};
      5'd28: r = {8'h66, 8'h74, 8'h79, 8'h70, {24{8'h00}}};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/magic_number_file_classifier.sv =====
// ----------------------------------------------------------------------------
// magic_number_file_classifier
// Classifies a file from its leading bytes against a signature ROM and an
// ASCII / UTF-16LE html marker search.
// ----------------------------------------------------------------------------
// Channel  Dir  Transaction
// in_*     in   one header byte (tdata[7:0]), tlast on the final byte of a file
// out_*    out  one type code per file (tdata[4:0]), after the tlast byte
// cfg_*    in   APB register write/read, html_window at byte address 0
//
// One byte per cycle while in_tready is high; the result follows in the cycle after tlast.
// Per-file state updates on each accepted byte and clears after tlast.
// in_tready drops only while a result is held and out_tready is low.
// Synchronous active-low reset; html_window resets to 20.
// ----------------------------------------------------------------------------
module magic_number_file_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [4:0] type_code, [7:5] zero
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mnfc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic [mnfc_pkg::WIN_W-1:0]     win_r;
  logic [mnfc_pkg::SIG_COUNT-1:0] alive_r, alive_nxt;
  logic [mnfc_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [2:0]                     asc_r, asc_nxt;
  logic [3:0]                     wide_r, wide_nxt;
  logic                           seen_r, seen_nxt;
  logic                           out_valid_r;
  logic [mnfc_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic                           accept;
  logic                           cfg_wr;
  logic [mnfc_pkg::POS_W:0]       n_bytes;
  logic [7:0]                     b;
  logic [7:0]                     want;
  logic                           wide_ok;

  assign b          = in_tdata;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, code_r};
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == mnfc_pkg::REG_HTML_WINDOW);
  assign cfg_prdata = (cfg_paddr[2] == mnfc_pkg::REG_HTML_WINDOW) ?
                      {26'd0, win_r} : 32'd0;
  assign n_bytes    = {1'b0, pos_r} + 7'd1;

  always_comb begin
    mnfc_pkg::sig_row_t row;
    alive_nxt = alive_r;
    for (int i = 0; i < mnfc_pkg::SIG_COUNT; i++) begin
      row = mnfc_pkg::sig_row(5'(i));
      if ((pos_r < 6'(mnfc_pkg::MAX_SIG_BYTES)) &&
          (pos_r < {1'b0, mnfc_pkg::sig_len(5'(i))}) &&
          (row[pos_r[4:0]] != b)) begin
        alive_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    code_nxt = seen_nxt ? mnfc_pkg::CODE_HTML : mnfc_pkg::CODE_OTHER;
    for (int i = mnfc_pkg::SIG_COUNT - 1; i >= 0; i--) begin
      if (alive_nxt[i] && ({2'b00, mnfc_pkg::sig_len(5'(i))} <= n_bytes)) begin
        code_nxt = 5'(i);
      end
    end
  end

  always_comb begin
    asc_nxt  = asc_r;
    wide_nxt = wide_r;
    seen_nxt = seen_r;
    want     = wide_r[0] ? 8'h00 : mnfc_pkg::marker_char(wide_r[2:1]);
    wide_ok  = !wide_r[3] && (b == want) && ((wide_r != 4'd0) || !pos_r[0]);
    if (pos_r < mnfc_pkg::POS_MAX) begin
      if (pos_r < win_r) begin
        if (!asc_r[2] && (b == mnfc_pkg::marker_char(asc_r[1:0]))) begin
          asc_nxt = asc_r + 3'd1;
        end else begin
          asc_nxt = (b == mnfc_pkg::CH_H) ? 3'd1 : 3'd0;
        end
        if (asc_nxt == 3'd4) begin
          seen_nxt = 1'b1;
        end
      end
      if ({1'b0, pos_r} < {win_r, 1'b0}) begin
        if (wide_ok) begin
          wide_nxt = wide_r + 4'd1;
        end else begin
          wide_nxt = (!pos_r[0] && (b == mnfc_pkg::CH_H)) ? 4'd1 : 4'd0;
        end
        if (wide_nxt == 4'd8) begin
          seen_nxt = 1'b1;
        end
      end
    end
    pos_nxt = (pos_r < mnfc_pkg::POS_MAX) ? pos_r + 6'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= mnfc_pkg::HTML_WIN_RST;
      alive_r     <= '1;
      pos_r       <= '0;
      asc_r       <= '0;
      wide_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        win_r <= cfg_pwdata[mnfc_pkg::WIN_W-1:0];
      end
      if (accept && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_tlast) begin
          alive_r <= '1;
          pos_r   <= '0;
          asc_r   <= '0;
          wide_r  <= '0;
          seen_r  <= 1'b0;
        end else begin
          alive_r <= alive_nxt;
          pos_r   <= pos_nxt;
          asc_r   <= asc_nxt;
          wide_r  <= wide_nxt;
          seen_r  <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      code_r <= code_nxt;
    end
  end

`ifndef SYNTHESIS
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> out_tvalid)
    else $error("no result after last byte");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (code_r <= mnfc_pkg::CODE_OTHER))
    else $error("type code out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> (pos_r == '0) && (&alive_r) && !seen_r)
    else $error("file state not cleared");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tlast && (pos_r == mnfc_pkg::POS_MAX) |=>
      (pos_r == mnfc_pkg::POS_MAX))
    else $error("position counter wrapped");
`endif

endmodule

// ===== tb/sv/tb_magic_number_file_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magic_number_file_classifier
// Streams file headers byte by byte into the classifier. A short directed
// table with its own expected codes comes first, then random files over
// several html_window settings, checked against an in-bench classifier that
// tracks signature mask, ASCII and UTF-16LE html searches and saturating byte
// position, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_magic_number_file_classifier;

  localparam int DIR_LEN     = 23;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 230;
  localparam int HOLD_CYCLES = 60;

  localparam int WIN_BYTE_ADDR = 4 * int'(mnfc_pkg::REG_HTML_WINDOW);
  localparam logic [mnfc_pkg::CFG_ADDR_W-1:0] WIN_ADDR =
    WIN_BYTE_ADDR[mnfc_pkg::CFG_ADDR_W-1:0];
  localparam logic [31:0] HTML_WORD = {mnfc_pkg::CH_H, mnfc_pkg::CH_T,
                                       mnfc_pkg::CH_M, mnfc_pkg::CH_L};

  localparam logic [mnfc_pkg::CODE_W-1:0] SIG_JPEG   = 5'd8;
  localparam logic [mnfc_pkg::CODE_W-1:0] SIG_MPEGTS = 5'd10;
  localparam logic [mnfc_pkg::CODE_W-1:0] SIG_BMP    = 5'd12;
  localparam logic [mnfc_pkg::CODE_W-1:0] SIG_M      = 5'd25;

  typedef struct packed {
    logic [7:0]                  data;
    logic                        last;
    logic                        typed;
    logic [mnfc_pkg::CODE_W-1:0] code;
  } step_t;

  localparam step_t [0:DIR_LEN-1] DIRECTED = {
    {8'h6D, 1'b1, 1'b1, SIG_M},
    {8'h42, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER}, {8'h4D, 1'b1, 1'b1, SIG_BMP},
    {8'h42, 1'b1, 1'b1, mnfc_pkg::CODE_OTHER},
    {8'h00, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER}, {8'h00, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'h01, 1'b1, 1'b1, SIG_MPEGTS},
    {8'hFF, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER}, {8'hD8, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'hFF, 1'b1, 1'b1, SIG_JPEG},
    {mnfc_pkg::CH_H, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_H, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_T, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_M, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_L, 1'b1, 1'b1, mnfc_pkg::CODE_HTML},
    {mnfc_pkg::CH_H, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'h00, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_T, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'h00, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_M, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'h00, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {mnfc_pkg::CH_L, 1'b0, 1'b0, mnfc_pkg::CODE_OTHER},
    {8'h00, 1'b1, 1'b1, mnfc_pkg::CODE_HTML}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = 8'h00;   // [7:0] data_byte
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;          // [4:0] type_code, [7:5] zero
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [mnfc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]                     cfg_pwdata = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  // classifier state
  logic [mnfc_pkg::SIG_COUNT-1:0] alive;
  logic [mnfc_pkg::POS_W-1:0]     byte_pos;
  logic [2:0]                     ascii_prog;
  logic [3:0]                     wide_prog;
  logic                           html_seen;
  logic [mnfc_pkg::WIN_W-1:0]     html_win;

  logic [mnfc_pkg::CODE_W-1:0] expected_types[$];
  logic [7:0]                  file_bytes[$];
  int                          mismatches = 0;
  int                          sent_bytes = 0;
  logic                        quiet = 1'b0;
  logic                        hold_req = 1'b0;

  magic_number_file_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_magic_number_file_classifier NOT OK");
    $finish;
  end

  // signature bytes, first byte in the top byte of the valid span
  function automatic void sig_entry(input int idx, output int len, output logic [223:0] pat);
    case (idx)
      0:  begin len = 3;  pat = 224'h435753; end
      1:  begin len = 3;  pat = 224'h465753; end
      2:  begin len = 4;  pat = 224'h7F454C46; end
      3:  begin len = 4;  pat = 224'hCAFEBABE; end
      4:  begin len = 4;  pat = 224'h504B0304; end
      5:  begin len = 6;  pat = 224'h526172211A07; end
      6:  begin len = 6;  pat = 224'h377ABCAF271C; end
      7:  begin len = 4;  pat = 224'h4D534346; end
      8:  begin len = 3;  pat = 224'hFFD8FF; end
      9:  begin len = 16; pat = 224'h89504E470D0A1A0A0000000D49484452; end
      10: begin len = 3;  pat = 224'h000001; end
      11: begin len = 4;  pat = 224'h47494638; end
      12: begin len = 2;  pat = 224'h424D; end
      13: begin len = 9;  pat = 224'hD0CF11E0A1B11AE100; end
      14: begin len = 7;  pat = 224'h255044462D312E; end
      15: begin len = 3;  pat = 224'h494433; end
      16: begin len = 9;  pat = 224'h234558544D33550D0A; end
      17: begin len = 12; pat = 224'hEFBBBF234558544D33550D0A; end
      18: begin len = 8;  pat = 224'h664C614300000022; end
      19: begin len = 3;  pat = 224'h000000; end
      20: begin len = 4;  pat = 224'h464C5601; end
      21: begin
        len = 28;
        pat = 224'h1A45DFA3934282886D6174726F736B61428781014285810118538067;
      end
      22: begin len = 4;  pat = 224'h000001BA; end
      23: begin len = 14; pat = 224'h4F676753_0002_0000000000000000; end
      24: begin len = 4;  pat = 224'h52494646; end
      25: begin len = 1;  pat = 224'h6D; end
      26: begin len = 16; pat = 224'h3026B2758E66CF11A6D900AA0062CE6C; end
      27: begin len = 9;  pat = 224'h2E524D460000001200; end
      default: begin len = 4; pat = 224'h66747970; end
    endcase
  endfunction

  function automatic void clear_file();
    alive      = '1;
    byte_pos   = '0;
    ascii_prog = '0;
    wide_prog  = '0;
    html_seen  = 1'b0;
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic last,
                                        output logic made,
                                        output logic [mnfc_pkg::CODE_W-1:0] code);
    int p, i, k, a, len;
    logic [223:0] pat;
    logic [7:0] want;
    logic ok, found;
    p = byte_pos;
    made = 1'b0;
    code = mnfc_pkg::CODE_OTHER;
    if (p < mnfc_pkg::MAX_SIG_BYTES) begin
      for (i = 0; i < mnfc_pkg::SIG_COUNT; i++) begin
        sig_entry(i, len, pat);
        if (p < len && pat[8*(len-1-p) +: 8] != b) alive[i] = 1'b0;
      end
    end
    if (p < int'(mnfc_pkg::POS_MAX)) begin
      if (p < int'(html_win)) begin
        a = ascii_prog;
        if (a < 4 && b == HTML_WORD[8*(3-a) +: 8]) a = a + 1;
        else a = (b == mnfc_pkg::CH_H) ? 1 : 0;
        ascii_prog = a[2:0];
        if (a == 4) html_seen = 1'b1;
      end
      if (p < 2 * int'(html_win)) begin
        k = wide_prog;
        ok = 1'b0;
        if (k < 8) begin
          want = k[0] ? 8'h00 : HTML_WORD[8*(3-k/2) +: 8];
          ok = (b == want) && (k != 0 || p[0] == 1'b0);
        end
        if (ok) k = k + 1;
        else k = (p[0] == 1'b0 && b == mnfc_pkg::CH_H) ? 1 : 0;
        wide_prog = k[3:0];
        if (k == 8) html_seen = 1'b1;
      end
      byte_pos = byte_pos + 1'b1;
    end
    if (last) begin
      made = 1'b1;
      found = 1'b0;
      for (i = 0; i < mnfc_pkg::SIG_COUNT; i++) begin
        sig_entry(i, len, pat);
        if (!found && alive[i] && len <= p + 1) begin
          code = i[mnfc_pkg::CODE_W-1:0];
          found = 1'b1;
        end
      end
      if (!found && html_seen) code = mnfc_pkg::CODE_HTML;
      clear_file();
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic [mnfc_pkg::CODE_W-1:0] code);
    logic made;
    logic [mnfc_pkg::CODE_W-1:0] got;
    while (!quiet && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    classify_byte(b, last, made, got);
    if (made) expected_types.push_back(typed ? code : got);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= WIN_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_window_reg();
    logic [31:0] rd;
    apb_xfer(1'b0, 32'h0, rd);
    if (rd !== {{(32-mnfc_pkg::WIN_W){1'b0}}, html_win}) begin
      $display("%0t: html_window read expected %0d actual %0d", $time, html_win, rd);
      mismatches++;
    end
  endtask

  task automatic set_window(input logic [31:0] word);
    logic [31:0] rd_unused;
    in_tvalid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_xfer(1'b1, word, rd_unused);
    html_win = word[mnfc_pkg::WIN_W-1:0];
    check_window_reg();
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] r;
    case ($urandom_range(7))
      0:       r = mnfc_pkg::CH_H;
      1:       r = mnfc_pkg::CH_T;
      2:       r = mnfc_pkg::CH_M;
      3:       r = mnfc_pkg::CH_L;
      4:       r = 8'h00;
      default: r = 8'($urandom);
    endcase
    return r;
  endfunction

  task automatic build_file();
    int kind, idx, len, cut, pre, tail, j, at;
    logic [223:0] pat;
    file_bytes.delete();
    kind = $urandom_range(9);
    if (kind <= 3) begin
      idx = $urandom_range(mnfc_pkg::SIG_COUNT - 1);
      sig_entry(idx, len, pat);
      cut = ($urandom_range(5) == 0) ? $urandom_range(len - 1) : len;
      for (j = 0; j < cut; j++) file_bytes.push_back(pat[8*(len-1-j) +: 8]);
      if (cut > 0 && $urandom_range(5) == 0)
        file_bytes[$urandom_range(cut - 1)] = 8'($urandom);
    end else if (kind <= 5) begin
      pre = $urandom_range(int'(html_win) + 1);
      for (j = 0; j < pre; j++) file_bytes.push_back(pick_byte());
      for (j = 0; j < 4; j++) file_bytes.push_back(HTML_WORD[8*(3-j) +: 8]);
    end else if (kind <= 7) begin
      pre = 2 * int'(html_win) + 1;
      pre = $urandom_range(pre > 66 ? 66 : pre);
      for (j = 0; j < pre; j++) file_bytes.push_back(pick_byte());
      for (j = 0; j < 8; j++)
        file_bytes.push_back(j[0] ? 8'h00 : HTML_WORD[8*(3-j/2) +: 8]);
    end else if (kind == 8) begin
      pre = $urandom_range(1, 10);
      for (j = 0; j < pre; j++) file_bytes.push_back(pick_byte());
    end else begin
      // long header, runs past the position counter
      pre = $urandom_range(68, 76);
      for (j = 0; j < pre; j++) file_bytes.push_back(pick_byte());
      if ($urandom_range(1)) begin
        at = 2 * $urandom_range(26, 30);
        for (j = 0; j < 8; j++)
          file_bytes[at+j] = j[0] ? 8'h00 : HTML_WORD[8*(3-j/2) +: 8];
      end
    end
    tail = $urandom_range(4);
    for (j = 0; j < tail; j++) file_bytes.push_back(pick_byte());
    if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
  endtask

  task automatic send_file();
    int j;
    for (j = 0; j < file_bytes.size(); j++)
      push_byte(file_bytes[j], j == file_bytes.size() - 1, 1'b0, mnfc_pkg::CODE_OTHER);
    sent_bytes += file_bytes.size();
  endtask

  // result side: random backpressure, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin : type_check
    logic [mnfc_pkg::CODE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_types.size() == 0) begin
        $display("%0t: type_code expected none actual %0d", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_types.pop_front();
        if (out_tdata !== {{(8-mnfc_pkg::CODE_W){1'b0}}, want}) begin
          $display("%0t: type_code expected %0d actual %0d", $time, want, out_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int k, ph;
    logic [31:0] word;
    html_win = mnfc_pkg::HTML_WIN_RST;
    clear_file();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_window_reg();

    for (k = 0; k < DIR_LEN; k++)
      push_byte(DIRECTED[k].data, DIRECTED[k].last, DIRECTED[k].typed, DIRECTED[k].code);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       word = 32'd4;
        2:       word = 32'd32;
        3:       word = 32'd0;
        4:       word = 32'hFFFF_FFFF;
        5:       word = 32'd1;
        6:       word = {8'($urandom_range(255)), 18'h0, 6'($urandom_range(4, 32))};
        7:       word = {26'h0, mnfc_pkg::HTML_WIN_RST};
        default: word = 32'h0;
      endcase
      if (ph != 0) set_window(word);
      if (ph == 1) hold_req = 1'b1;
      quiet = (ph == 2);
      sent_bytes = 0;
      while (sent_bytes < PHASE_BYTES) begin
        build_file();
        send_file();
      end
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (expected_types.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_magic_number_file_classifier OK");
    end else begin
      $display("tb_magic_number_file_classifier NOT OK");
    end
    $finish;
  end

endmodule
